### hw/rtl/uartrx_pkg.sv
// shared types and constants for the uart receive ring with read replay
// used by uartrx_queue and uart_rx_ring_with_read_replay_core
package uartrx_pkg;

    localparam int unsigned QUEUE_DEPTH_DFLT = 1024;
    localparam logic [7:0]  EMPTY_BYTE       = 8'hff;

    // input and output beat packing
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_TUSER_W = 3;

    localparam logic [2:0] GOOD_OFFSET = 3'd0;
    localparam logic [3:0] GOOD_SIZE   = 4'd1;

    typedef enum logic [1:0] {
        FUNC_HOST  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic       access_error;
        logic       tx_valid;
        logic       read_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
    } t_result;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] byte_in;
    } t_q_cmd;

    typedef struct packed {
        logic       empty;
        logic [7:0] rd_data;
    } t_q_stat;

endpackage

### hw/rtl/uartrx_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module uartrx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/uartrx_queue.sv
// receive ring queue: head and tail pointers around one uartrx_ram
// depends on uartrx_pkg and uartrx_ram
module uartrx_queue #(
    parameter int unsigned QUEUE_DEPTH = uartrx_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  uartrx_pkg::t_q_cmd  i_cmd,
    output uartrx_pkg::t_q_stat o_stat
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] head_inc, tail_inc;
    logic [7:0]    rdata;

    assign head_inc = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_cmd.push) begin
            n_tail = tail_inc;
            // full: drop the oldest byte
            if (tail_inc == r_head) begin
                n_head = head_inc;
            end
        end else if (i_cmd.pop && (r_head != r_tail)) begin
            n_head = head_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    uartrx_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.byte_in),
        .i_re    (i_cmd.pop),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign o_stat.empty   = (r_head == r_tail);
    assign o_stat.rd_data = rdata;

endmodule

### hw/rtl/uart_rx_ring_with_read_replay_core.sv
// uart data register with receive ring queue and read replay, top level
// depends on uartrx_pkg and uartrx_queue
//
// one input beat per event on the s_axis side, one result beat per event on
// the m_axis side. tuser carries the event kind (host byte, bus read, bus
// write) going in, and the read_valid / tx_valid / access_error flags going
// out. host bytes go into a ring of QUEUE_DEPTH-1 usable slots, overwriting
// the oldest byte when full. a bus read returns the held byte, refilling it
// from the ring once its replays are used up (0xff when the ring is empty,
// replayed once; any other byte twice).
// a beat is registered in the result stage when it is accepted and then
// moves on to the output register; a read that refills from the ring first
// waits in the result stage for the registered ram read. throughput is one
// event per cycle while the output is not stalled, except that a refilling read
// holds tready low while the registered ram read returns the refill byte.
// reset (synchronous, active low) empties the ring, sets the held byte to
// 0xff with no replays left and drops any pending result; ring contents are
// not cleared. a stalled receiver holds the output register; one more result
// waits in the result stage, after which tready drops until m_axis_tready
// returns.
module uart_rx_ring_with_read_replay_core #(
    parameter int unsigned QUEUE_DEPTH = uartrx_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // host_byte[7:0], write_byte[15:8], offset[18:16], access_size[22:19]
    input  logic [uartrx_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // func[1:0]
    input  logic [uartrx_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // read_data[7:0], tx_byte[15:8]
    output logic [uartrx_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // read_valid[0], tx_valid[1], access_error[2]
    output logic [uartrx_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    uartrx_pkg::t_func   func;
    logic [7:0]          host_byte;
    logic [7:0]          write_byte;
    logic [2:0]          offset;
    logic [3:0]          access_size;
    logic                bad;
    logic                accept;
    logic                s1_move;

    uartrx_pkg::t_q_cmd  q_cmd;
    uartrx_pkg::t_q_stat q_stat;

    logic                r_s1_valid, n_s1_valid;
    logic                r_s1_pop,   n_s1_pop;
    logic                r_s1_empty, n_s1_empty;
    uartrx_pkg::t_result r_s1,       n_s1;
    logic                r_o_valid,  n_o_valid;
    uartrx_pkg::t_result r_o,        n_o;
    logic [7:0]          r_held,     n_held;
    logic [1:0]          r_replays,  n_replays;
    logic [7:0]          pop_byte;

    assign func        = uartrx_pkg::t_func'(i_s_axis_tuser);
    assign host_byte   = i_s_axis_tdata[7:0];
    assign write_byte  = i_s_axis_tdata[15:8];
    assign offset      = i_s_axis_tdata[18:16];
    assign access_size = i_s_axis_tdata[22:19];
    assign bad         = (offset != uartrx_pkg::GOOD_OFFSET) ||
                         (access_size != uartrx_pkg::GOOD_SIZE);

    // result stage moves on once a refill has resolved and the output is free
    assign s1_move         = r_s1_valid && !r_s1_pop && (!r_o_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_pop && (!r_s1_valid || s1_move);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign pop_byte = r_s1_empty ? uartrx_pkg::EMPTY_BYTE : q_stat.rd_data;

    always_comb begin
        q_cmd         = '0;
        q_cmd.byte_in = host_byte;
        n_s1_valid    = r_s1_valid;
        n_s1_pop      = r_s1_pop;
        n_s1_empty    = r_s1_empty;
        n_s1          = r_s1;
        n_held        = r_held;
        n_replays     = r_replays;

        if (r_s1_pop) begin
            // registered ram byte is here: finish the refill
            n_held            = pop_byte;
            n_replays         = (pop_byte == uartrx_pkg::EMPTY_BYTE) ? 2'd0 : 2'd1;
            n_s1.read_data    = pop_byte;
            n_s1_pop          = 1'b0;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end

        if (accept) begin
            n_s1_valid = 1'b1;
            n_s1       = '0;
            unique case (func)
                uartrx_pkg::FUNC_HOST: begin
                    q_cmd.push = 1'b1;
                end
                uartrx_pkg::FUNC_READ: begin
                    if (bad) begin
                        n_s1.access_error = 1'b1;
                    end else begin
                        n_s1.read_valid = 1'b1;
                        if (r_replays == 2'd0) begin
                            q_cmd.pop  = 1'b1;
                            n_s1_pop   = 1'b1;
                            n_s1_empty = q_stat.empty;
                        end else begin
                            n_s1.read_data = r_held;
                            n_replays      = r_replays - 2'd1;
                        end
                    end
                end
                uartrx_pkg::FUNC_WRITE: begin
                    if (bad) begin
                        n_s1.access_error = 1'b1;
                    end else begin
                        n_s1.tx_valid = 1'b1;
                        n_s1.tx_byte  = write_byte;
                    end
                end
                uartrx_pkg::FUNC_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        n_o       = r_o;
        if (s1_move) begin
            n_o_valid = 1'b1;
            n_o       = r_s1;
        end else if (i_m_axis_tready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_pop   <= 1'b0;
            r_o_valid  <= 1'b0;
            r_held     <= uartrx_pkg::EMPTY_BYTE;
            r_replays  <= 2'd0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s1_pop   <= n_s1_pop;
            r_o_valid  <= n_o_valid;
            r_held     <= n_held;
            r_replays  <= n_replays;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_empty <= n_s1_empty;
        r_s1       <= n_s1;
        r_o        <= n_o;
    end

    uartrx_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o.tx_byte, r_o.read_data};
    assign o_m_axis_tuser  = {r_o.access_error, r_o.tx_valid, r_o.read_valid};

    // a result is at most one of read, transmit or error
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot0(o_m_axis_tuser))
        else $error("result carries more than one kind flag");

    // replay count never reaches three
    a_replays_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_replays != 2'd3)
        else $error("replay count out of range");

    // after a refill, an 0xff byte has no replays left and any other has one
    a_refill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_pop |=> ((r_held == uartrx_pkg::EMPTY_BYTE) == (r_replays == 2'd0)))
        else $error("refill set a wrong replay count");

    // the refill cycle is an interlock: nothing is taken while it resolves
    a_refill_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && q_cmd.pop) |=> !accept)
        else $error("beat accepted while a refill was pending");

endmodule
